### sv/deq_pkg.sv
// types and constants shared by the double-ended queue core
// no dependencies; compiled before the core
package deq_pkg;

  // queue depth; the occupancy field (CNT_W bits) is wide enough to count up to it
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [WORD_W-1:0]  push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_value;
    status_t                   status;
    logic [CNT_W-1:0]          occupancy;
  } out_word_t;

endpackage

### sv/double_ended_queue_core.sv
// bounded double-ended queue core: circular entry memory, head index, count
// depends on deq_pkg for word types, command and status codes
// a word is taken into the pending result registers and the entry memory read register,
// then its result is registered at the output in S_FINISH once the output is free
// a new word is not taken until the result of the last one has been registered at the output
// reset: head and count clear at once, no clearing pass; entry memory is not reset
module double_ended_queue_core
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_FINISH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // result of the word in flight, waiting for the memory read
  status_t          pend_status;
  logic [CNT_W-1:0] pend_occ;
  logic             pend_pop;

  logic             accept;
  logic             out_free;
  logic             is_push;
  logic             is_empty;
  logic             is_full;
  logic [SUM_W-1:0] sum_back;
  logic [SUM_W-1:0] sum_last;
  logic [IDX_W-1:0] back_pos;
  logic [IDX_W-1:0] last_pos;
  logic [IDX_W-1:0] front_pos;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  status_t          status_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign is_push  = (in_data.command == CMD_PUSH_FRONT) || (in_data.command == CMD_PUSH_BACK);
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(DEPTH));

  // circular positions, sums stay below twice the depth
  assign sum_back = SUM_W'(head) + SUM_W'(count);
  assign sum_last = sum_back - SUM_W'(1);
  assign back_pos = (sum_back >= SUM_W'(DEPTH)) ? IDX_W'(sum_back - SUM_W'(DEPTH))
                                                 : IDX_W'(sum_back);
  assign last_pos = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                 : IDX_W'(sum_last);
  assign front_pos = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
  assign head_inc  = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);

  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = ST_DONE;
    wr_en       = 1'b0;
    wr_addr     = back_pos;
    rd_addr     = head;
    unique case (in_data.command)
      CMD_PUSH_FRONT: begin
        wr_addr = front_pos;
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          head_next  = front_pos;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        rd_addr = last_pos;
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // entry memory, synchronous write and registered read
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= in_data.push_value;
    end
    if (accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_occ    <= count_next;
      pend_pop    <= !is_push && !is_empty;
    end
    if (state == S_FINISH && out_free) begin
      out_data.status    <= pend_status;
      out_data.occupancy <= pend_occ;
      if (pend_pop) begin
        out_data.popped_value <= rd_data;
      end else if (pend_status == ST_EMPTY) begin
        out_data.popped_value <= '1;
      end else begin
        out_data.popped_value <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### dv/deq_checker.sv
// checker for the double-ended queue core: watches both channels, predicts each result
// and compares it with what the core returns; depends on deq_pkg for word types and codes
`timescale 1ns / 1ps

module deq_checker
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        errors,
  output int        pending,
  output int        compared,
  output int        drops,
  output int        empties
);

  // predicted queue contents
  logic [WORD_W-1:0] slots [DEPTH];
  int                head_pos;
  int                fill;
  out_word_t         due_results [$];

  initial begin
    errors   = 0;
    pending  = 0;
    compared = 0;
    drops    = 0;
    empties  = 0;
    head_pos = 0;
    fill     = 0;
  end

  function automatic out_word_t deque_step(input in_word_t w);
    out_word_t r;
    int        slot;
    r = '0;
    r.status = ST_DONE;
    case (w.command) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
          drops++;
        end else begin
          if (w.command == CMD_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            slot = head_pos;
          end else begin
            slot = (head_pos + fill) % DEPTH;
          end
          slots[slot] = w.push_value;
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          r.popped_value = '1;
          r.status = ST_EMPTY;
          empties++;
        end else begin
          if (w.command == CMD_POP_FRONT) begin
            r.popped_value = slots[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            r.popped_value = slots[(head_pos + fill - 1) % DEPTH];
          end
          fill--;
        end
      end
    endcase
    r.occupancy = CNT_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        due_results.push_back(deque_step(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: popped_value %0d status %0d occupancy %0d",
                 out_data.popped_value, out_data.status, out_data.occupancy);
          errors++;
        end else begin
          want = due_results.pop_front();
          compared++;
          if (out_data.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, got %0d", want.popped_value,
                   out_data.popped_value);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_data.occupancy);
            errors++;
          end
        end
      end
      pending = due_results.size();
    end
  end

endmodule

### dv/double_ended_queue_core_test.sv
// top of the double-ended queue testbench: clock, reset, command stimulus and verdict
// depends on deq_pkg, double_ended_queue_core and deq_checker
`timescale 1ns / 1ps

module double_ended_queue_core_test;
  import deq_pkg::*;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  int errors;
  int pending;
  int compared;
  int drops;
  int empties;
  int sent = 0;
  bit no_idle = 1'b0;

  double_ended_queue_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  deq_checker checker_inst (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .compared  (compared),
    .drops     (drops),
    .empties   (empties)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input cmd_t c, input logic [WORD_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: c, push_value: v};
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // result side back-pressure
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int   push_pct;
    int   burst;
    cmd_t c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pops, fill to the brim with extreme words, overfill, then pop both ends
    send_word(CMD_POP_FRONT, 32'h1234_5678);
    send_word(CMD_POP_BACK, 32'hffff_ffff);
    for (int i = 0; i < DEPTH; i++) begin
      c = (i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      case (i % 4)
        0: send_word(c, 32'h7fff_ffff);
        1: send_word(c, 32'h8000_0000);
        2: send_word(c, 32'hffff_ffff);
        default: send_word(c, 32'h0000_0000);
      endcase
    end
    send_word(CMD_PUSH_FRONT, 32'h5555_5555);
    send_word(CMD_PUSH_BACK, 32'haaaa_aaaa);
    send_word(CMD_POP_FRONT, 32'h0);
    send_word(CMD_POP_BACK, 32'h0);

    // bursts leaning to filling, draining or churning, so full and empty both recur
    while (sent < 2000) begin
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(10, 60);
      repeat (burst) begin
        if ($urandom_range(0, 99) < push_pct)
          c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else
          c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        send_word(c, pick_value());
      end
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // let the checker log the last word before polling its backlog
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d commands sent, %0d results compared", sent, compared);
    $display("%0d pushes dropped on a full queue, %0d pops on an empty queue", drops, empties);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
